FILE: sv/amsp_pkg.sv
// ----------------------------------------------------------------------------
// amsp_pkg: shared definitions for the adjacency-matrix shortest-path engine
// Field widths, command codes, the controller state type and the saturating
// cost adder used by the relaxation pipeline.
// ----------------------------------------------------------------------------
package amsp_pkg;

    localparam int unsigned MaxVerticesDefault = 64;
    localparam int unsigned WeightBitsDefault  = 24;

    localparam int unsigned VertexWidth = 6;
    localparam int unsigned WeightWidth = 24;
    localparam int unsigned CostWidth   = 32;
    localparam int unsigned CountWidth  = 7;
    localparam int unsigned SDataWidth  = 40;
    localparam int unsigned MDataWidth  = 40;

    localparam logic [CostWidth-1:0] CostMax = '1;

    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_EDGE2,
        ST_INIT,
        ST_RELAX,
        ST_ROUND,
        ST_TRACE_CHK,
        ST_TRACE_WAIT,
        ST_PATH_RD,
        ST_PATH_OUT,
        ST_FAIL
    } state_t;

    typedef struct packed {
        logic                 we;
        logic [CostWidth-1:0] cost;
    } relax_upd_t;

    function automatic logic [CostWidth-1:0] sat_add(input logic [CostWidth-1:0] a,
                                                     input logic [CostWidth-1:0] b);
        logic [CostWidth:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CostWidth] ? CostMax : s[CostWidth-1:0];
    endfunction

endpackage

FILE: sv/amsp_relax_unit.sv
// ----------------------------------------------------------------------------
// amsp_relax_unit: two-stage edge relaxation and running minimum
// Takes one neighbor per cycle, forms the candidate cost, decides the update
// and tracks the cheapest discovered, unvisited vertex for the next round.
// ----------------------------------------------------------------------------
module amsp_relax_unit #(
    parameter int unsigned VERT_BITS   = 6,
    parameter int unsigned WEIGHT_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pass_start,
    input  logic                           in_valid,
    input  logic [VERT_BITS-1:0]           in_idx,
    input  logic [amsp_pkg::CostWidth-1:0] cur_cost,
    input  logic [WEIGHT_BITS:0]           edge_word,
    input  logic [amsp_pkg::CostWidth-1:0] old_cost,
    input  logic                           in_visited,
    input  logic                           in_disc,
    output amsp_pkg::relax_upd_t           upd,
    output logic [VERT_BITS-1:0]           upd_idx,
    output logic                           busy,
    output logic                           found,
    output logic [VERT_BITS-1:0]           best_idx,
    output logic [amsp_pkg::CostWidth-1:0] best_cost
);
    import amsp_pkg::*;

    logic                 s2_valid_reg;
    logic [VERT_BITS-1:0] s2_idx_reg;
    logic [CostWidth-1:0] s2_sum_reg;
    logic [CostWidth-1:0] s2_old_reg;
    logic                 s2_present_reg;
    logic                 s2_vis_reg;
    logic                 s2_disc_reg;

    logic                 found_reg, found_next;
    logic [VERT_BITS-1:0] best_idx_reg, best_idx_next;
    logic [CostWidth-1:0] best_cost_reg, best_cost_next;

    logic                 take;
    logic [CostWidth-1:0] new_cost;
    logic                 cand;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= in_valid;
        end
        s2_idx_reg     <= in_idx;
        s2_sum_reg     <= sat_add(cur_cost, CostWidth'(edge_word[WEIGHT_BITS-1:0]));
        s2_old_reg     <= old_cost;
        s2_present_reg <= edge_word[WEIGHT_BITS];
        s2_vis_reg     <= in_visited;
        s2_disc_reg    <= in_disc;
    end

    // A neighbor cost is replaced only by a strictly smaller one.
    assign take     = s2_valid_reg && s2_present_reg && !s2_vis_reg &&
                      (!s2_disc_reg || (s2_sum_reg < s2_old_reg));
    assign new_cost = take ? s2_sum_reg : s2_old_reg;
    assign cand     = s2_valid_reg && !s2_vis_reg && (s2_disc_reg || take);

    always_comb begin
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_cost_next = best_cost_reg;
        if (pass_start) begin
            found_next = 1'b0;
        end else if (cand && (!found_reg || (new_cost < best_cost_reg))) begin
            found_next     = 1'b1;
            best_idx_next  = s2_idx_reg;
            best_cost_next = new_cost;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        best_idx_reg  <= best_idx_next;
        best_cost_reg <= best_cost_next;
    end

    assign upd.we    = take;
    assign upd.cost  = s2_sum_reg;
    assign upd_idx   = s2_idx_reg;
    assign busy      = s2_valid_reg;
    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_cost = best_cost_reg;

endmodule

FILE: sv/adjacency_matrix_shortest_path.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_shortest_path: Dijkstra engine over a stored edge matrix
// Stores directed edge weights and answers shortest-path queries.
// ----------------------------------------------------------------------------
// Usage. Each input beat carries a command in s_tuser: clear all edges, add
// an edge (both directions unless one_way is set), or query a path. Clear
// and add-edge beats give no output. A query gives the path vertices from
// source to destination, one output beat each, every beat with the total
// cost; m_tlast marks the final beat. An unreachable destination gives one
// beat with reached low, vertex 0 and cost 0. vertex_count is written on
// cfg_we/cfg_wdata and is clamped into 2..MAX_VERTICES, 64 at the defaults.
// The user writes it only while the block is idle; the block does not
// enforce this. An add edge stored both ways writes the reverse entry in
// ST_EDGE2 (one matrix write port). A clear sweeps the matrix one entry a
// cycle. A query runs one relaxation pass over the n neighbors per finalized
// vertex, walks predecessors back from the destination and sends one output
// beat per path vertex; the matrix read port sets the pace of a pass. Reset
// runs the same clearing sweep before the first beat is accepted. s_tready
// is low while any command is in progress. The result sits in an output
// register, so a stalled receiver holds the walk-out but the block returns
// to idle as soon as the last beat is loaded.
// ----------------------------------------------------------------------------
module adjacency_matrix_shortest_path #(
    parameter int unsigned MAX_VERTICES = amsp_pkg::MaxVerticesDefault,
    parameter int unsigned WEIGHT_BITS  = amsp_pkg::WeightBitsDefault
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [amsp_pkg::CountWidth-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] from_vertex, [11:6] to_vertex, [35:12] edge_weight, [36] one_way
    input  logic [amsp_pkg::SDataWidth-1:0] s_tdata,
    // [1:0] command
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] path_vertex, [37:6] path_cost
    output logic [amsp_pkg::MDataWidth-1:0] m_tdata,
    // [0] reached
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import amsp_pkg::*;

    localparam int unsigned VW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned AW     = 2 * VW;
    localparam int unsigned EDEPTH = 1 << AW;
    localparam int unsigned VDEPTH = 1 << VW;
    localparam int unsigned EWW    = WEIGHT_BITS + 1;
    localparam int unsigned VMW    = VW + CostWidth;

    // Input field unpacking.
    logic [1:0]             in_cmd;
    logic [VertexWidth-1:0] in_from, in_to;
    logic [WeightWidth-1:0] in_weight;
    logic                   in_one_way;
    logic [WEIGHT_BITS-1:0] in_w;
    logic [CostWidth-1:0]   in_w32;

    assign in_cmd     = s_tuser;
    assign in_from    = s_tdata[5:0];
    assign in_to      = s_tdata[11:6];
    assign in_weight  = s_tdata[35:12];
    assign in_one_way = s_tdata[36];
    assign in_w32     = CostWidth'(in_weight);
    assign in_w       = in_w32[WEIGHT_BITS-1:0];

    // Registers.
    state_t                  state_reg, state_next;
    logic [CountWidth-1:0]   vc_reg, vc_next;
    logic [AW-1:0]           sweep_reg, sweep_next;
    logic [AW-1:0]           e2_addr_reg, e2_addr_next;
    logic [WEIGHT_BITS-1:0]  ew_reg, ew_next;
    logic [VW-1:0]           src_reg, src_next;
    logic [VW-1:0]           dst_reg, dst_next;
    logic [VW-1:0]           cur_reg, cur_next;
    logic [CostWidth-1:0]    cur_cost_reg, cur_cost_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] disc_reg, disc_next;
    logic [CountWidth-1:0]   rd_i_reg, rd_i_next;
    logic                    p1_v_reg, p1_v_next;
    logic [VW-1:0]           p1_i_reg, p1_i_next;
    logic [CountWidth-1:0]   hops_reg, hops_next;
    logic [VW-1:0]           tcur_reg, tcur_next;
    logic                    m_valid_reg, m_valid_next;
    logic [VertexWidth-1:0]  m_vertex_reg, m_vertex_next;
    logic [CostWidth-1:0]    m_cost_reg, m_cost_next;
    logic                    m_reached_reg, m_reached_next;
    logic                    m_last_reg, m_last_next;

    // Memories: edge matrix, per-vertex {predecessor, cost}, path stack.
    logic [EWW-1:0] edge_mem [EDEPTH];
    logic [VMW-1:0] vert_mem [VDEPTH];
    logic [VW-1:0]  chain_mem [VDEPTH];

    logic           e_we;
    logic [AW-1:0]  e_waddr, e_raddr;
    logic [EWW-1:0] e_wdata, e_rdata_reg;
    logic           v_we;
    logic [VW-1:0]  v_waddr, v_raddr;
    logic [VMW-1:0] v_wdata, v_rdata_reg;
    logic           c_we;
    logic [VW-1:0]  c_waddr, c_raddr;
    logic [VW-1:0]  c_wdata, c_rdata_reg;

    always_ff @(posedge aclk) begin
        if (e_we) begin
            edge_mem[e_waddr] <= e_wdata;
        end
        e_rdata_reg <= edge_mem[e_raddr];
    end

    always_ff @(posedge aclk) begin
        if (v_we) begin
            vert_mem[v_waddr] <= v_wdata;
        end
        v_rdata_reg <= vert_mem[v_raddr];
    end

    always_ff @(posedge aclk) begin
        if (c_we) begin
            chain_mem[c_waddr] <= c_wdata;
        end
        c_rdata_reg <= chain_mem[c_raddr];
    end

    // Relaxation pipeline.
    relax_upd_t           upd;
    logic [VW-1:0]        upd_idx;
    logic                 relax_busy;
    logic                 relax_found;
    logic [VW-1:0]        relax_best_idx;
    logic [CostWidth-1:0] relax_best_cost;
    logic                 pass_start;

    amsp_relax_unit #(
        .VERT_BITS   (VW),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_relax (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pass_start (pass_start),
        .in_valid   (p1_v_reg),
        .in_idx     (p1_i_reg),
        .cur_cost   (cur_cost_reg),
        .edge_word  (e_rdata_reg),
        .old_cost   (v_rdata_reg[CostWidth-1:0]),
        .in_visited (visited_reg[p1_i_reg]),
        .in_disc    (disc_reg[p1_i_reg]),
        .upd        (upd),
        .upd_idx    (upd_idx),
        .busy       (relax_busy),
        .found      (relax_found),
        .best_idx   (relax_best_idx),
        .best_cost  (relax_best_cost)
    );

    // Common decode.
    logic [CountWidth-1:0] n_val;
    logic [CountWidth-1:0] max_v;
    logic                  acc;
    logic                  edge_ok;
    logic                  range_ok;
    logic                  out_free;
    logic                  nx_found;
    logic [VW-1:0]         nx_idx;
    logic [CostWidth-1:0]  nx_cost;
    logic                  relax_done;
    logic                  trace_stop;
    logic [CountWidth-1:0] hops_m1;

    assign max_v    = CountWidth'(MAX_VERTICES);
    assign n_val    = (vc_reg < CountWidth'(2)) ? CountWidth'(2) :
                      ((vc_reg > max_v) ? max_v : vc_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    // Self-loops and vertices outside the matrix are dropped.
    assign edge_ok  = (in_from != in_to) && ({1'b0, in_from} < max_v) &&
                      ({1'b0, in_to} < max_v);
    assign range_ok = ({1'b0, in_from} < n_val) && ({1'b0, in_to} < n_val);
    assign out_free = !m_valid_reg || m_tready;

    // The first round of a query finalizes the source without a pass.
    assign nx_found = (state_reg == ST_INIT) ? 1'b1 : relax_found;
    assign nx_idx   = (state_reg == ST_INIT) ? src_reg : relax_best_idx;
    assign nx_cost  = (state_reg == ST_INIT) ? '0 : relax_best_cost;

    assign relax_done = (rd_i_reg == n_val) && !p1_v_reg && !relax_busy;
    assign trace_stop = (tcur_reg == src_reg) || (hops_reg >= n_val);
    assign hops_m1    = hops_reg - CountWidth'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    unique case (in_cmd)
                        CMD_CLEAR:    state_next = ST_CLEAR;
                        CMD_ADD_EDGE: state_next = (edge_ok && !in_one_way) ? ST_EDGE2 : ST_IDLE;
                        CMD_QUERY:    state_next = range_ok ? ST_INIT : ST_FAIL;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (sweep_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EDGE2: state_next = ST_IDLE;
            ST_INIT, ST_ROUND: begin
                if (!nx_found) begin
                    state_next = ST_FAIL;
                end else if (nx_idx == dst_reg) begin
                    state_next = ST_TRACE_CHK;
                end else begin
                    state_next = ST_RELAX;
                end
            end
            ST_RELAX: begin
                if (relax_done) begin
                    state_next = ST_ROUND;
                end
            end
            ST_TRACE_CHK:  state_next = trace_stop ? ST_PATH_RD : ST_TRACE_WAIT;
            ST_TRACE_WAIT: state_next = ST_TRACE_CHK;
            ST_PATH_RD:    state_next = ST_PATH_OUT;
            ST_PATH_OUT: begin
                if (out_free) begin
                    state_next = (hops_reg == CountWidth'(1)) ? ST_IDLE : ST_PATH_RD;
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        vc_next        = cfg_we ? cfg_wdata : vc_reg;
        sweep_next     = sweep_reg;
        e2_addr_next   = e2_addr_reg;
        ew_next        = ew_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        cur_next       = cur_reg;
        cur_cost_next  = cur_cost_reg;
        visited_next   = visited_reg;
        disc_next      = disc_reg;
        rd_i_next      = rd_i_reg;
        p1_v_next      = 1'b0;
        p1_i_next      = p1_i_reg;
        hops_next      = hops_reg;
        tcur_next      = tcur_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_vertex_next  = m_vertex_reg;
        m_cost_next    = m_cost_reg;
        m_reached_next = m_reached_reg;
        m_last_next    = m_last_reg;
        pass_start     = 1'b0;

        e_we    = 1'b0;
        e_waddr = sweep_reg;
        e_wdata = '0;
        e_raddr = {cur_reg, rd_i_reg[VW-1:0]};
        v_we    = 1'b0;
        v_waddr = upd_idx;
        v_wdata = {cur_reg, upd.cost};
        v_raddr = rd_i_reg[VW-1:0];
        c_we    = 1'b0;
        c_waddr = hops_reg[VW-1:0];
        c_wdata = dst_reg;
        c_raddr = hops_m1[VW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    src_next     = in_from[VW-1:0];
                    dst_next     = in_to[VW-1:0];
                    sweep_next   = '0;
                    e2_addr_next = {in_to[VW-1:0], in_from[VW-1:0]};
                    ew_next      = in_w;
                    if ((in_cmd == CMD_ADD_EDGE) && edge_ok) begin
                        e_we    = 1'b1;
                        e_waddr = {in_from[VW-1:0], in_to[VW-1:0]};
                        e_wdata = {1'b1, in_w};
                    end
                end
            end
            ST_CLEAR: begin
                e_we       = 1'b1;
                sweep_next = sweep_reg + AW'(1);
            end
            ST_EDGE2: begin
                e_we    = 1'b1;
                e_waddr = e2_addr_reg;
                e_wdata = {1'b1, ew_reg};
            end
            ST_INIT, ST_ROUND: begin
                if (state_reg == ST_INIT) begin
                    v_we         = 1'b1;
                    v_waddr      = src_reg;
                    v_wdata      = {src_reg, {CostWidth{1'b0}}};
                    visited_next = '0;
                    disc_next    = MAX_VERTICES'(1) << src_reg;
                end
                if (nx_found) begin
                    cur_next      = nx_idx;
                    cur_cost_next = nx_cost;
                    visited_next  = ((state_reg == ST_INIT) ? '0 : visited_reg) |
                                    (MAX_VERTICES'(1) << nx_idx);
                    if (nx_idx == dst_reg) begin
                        c_we      = 1'b1;
                        c_waddr   = '0;
                        c_wdata   = dst_reg;
                        hops_next = CountWidth'(1);
                        tcur_next = dst_reg;
                    end else begin
                        rd_i_next  = '0;
                        pass_start = 1'b1;
                    end
                end
            end
            ST_RELAX: begin
                // Read the next neighbor while the update for an earlier one is written back.
                if (rd_i_reg != n_val) begin
                    p1_v_next = 1'b1;
                    p1_i_next = rd_i_reg[VW-1:0];
                    rd_i_next = rd_i_reg + CountWidth'(1);
                end
                if (upd.we) begin
                    v_we               = 1'b1;
                    disc_next[upd_idx] = 1'b1;
                end
            end
            ST_TRACE_CHK: begin
                v_raddr = tcur_reg;
            end
            ST_TRACE_WAIT: begin
                c_we      = 1'b1;
                c_wdata   = v_rdata_reg[CostWidth +: VW];
                tcur_next = v_rdata_reg[CostWidth +: VW];
                hops_next = hops_reg + CountWidth'(1);
            end
            ST_PATH_RD: begin
            end
            ST_PATH_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_vertex_next  = VertexWidth'(c_rdata_reg);
                    m_cost_next    = cur_cost_reg;
                    m_reached_next = 1'b1;
                    m_last_next    = (hops_reg == CountWidth'(1));
                    hops_next      = hops_m1;
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_vertex_next  = '0;
                    m_cost_next    = '0;
                    m_reached_next = 1'b0;
                    m_last_next    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sweep_reg   <= '0;
            vc_reg      <= CountWidth'(64);
            p1_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            vc_reg      <= vc_next;
            p1_v_reg    <= p1_v_next;
            m_valid_reg <= m_valid_next;
        end
        e2_addr_reg   <= e2_addr_next;
        ew_reg        <= ew_next;
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        cur_reg       <= cur_next;
        cur_cost_reg  <= cur_cost_next;
        visited_reg   <= visited_next;
        disc_reg      <= disc_next;
        rd_i_reg      <= rd_i_next;
        p1_i_reg      <= p1_i_next;
        hops_reg      <= hops_next;
        tcur_reg      <= tcur_next;
        m_vertex_reg  <= m_vertex_next;
        m_cost_reg    <= m_cost_next;
        m_reached_reg <= m_reached_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_cost_reg, m_vertex_reg};
    assign m_tuser  = m_reached_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: sv/amsp_checker.sv
// ----------------------------------------------------------------------------
// amsp_checker: port-level checks for the shortest-path engine
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module amsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import amsp_pkg::*;

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("output beat changed while stalled");

    // An unreachable answer is a single zero beat.
    a_unreached: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("unreachable beat malformed");

    // A query always keeps the engine busy in the following cycle.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_QUERY) |=> !s_tready)
        else $error("accepted a beat right after a query");

    // Reset starts the matrix clearing sweep.
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("ready right after reset");

endmodule

bind adjacency_matrix_shortest_path amsp_checker u_amsp_checker (.*);

FILE: sim/tb_adjacency_matrix_shortest_path.sv
// ----------------------------------------------------------------------------
// tb_adjacency_matrix_shortest_path: self-checking bench for the path engine
// Drives clear, add-edge and query beats on the input stream. Every query is
// answered in advance by a behavioral Dijkstra search over a local copy of the
// edge matrix. Output beats are compared field by field with that answer.
// ----------------------------------------------------------------------------
module tb_adjacency_matrix_shortest_path;
    timeunit 1ns;
    timeprecision 1ps;
    import amsp_pkg::*;

    localparam int NV = 64;
    localparam int CYCLE_LIMIT = 2_000_000;

    // The one command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One expected output beat of a query.
    typedef struct {
        logic [5:0]  vertex;
        logic [31:0] cost;
        logic        reached;
        logic        last;
    } path_beat_t;

    // One row of the directed stimulus table. A row with a typed answer has
    // has_answer set; its single expected beat is checked against the search.
    typedef struct {
        logic [1:0]  cmd;
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [23:0] weight;
        logic        one_way;
        logic        has_answer;
        path_beat_t  answer;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [SDataWidth-1:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_CLEAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [MDataWidth-1:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Local model of the block state.
    logic [23:0] weight_of [NV][NV];
    logic        has_edge  [NV][NV];
    logic [6:0]  count_reg;

    path_beat_t  pending_beats[$];
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    adjacency_matrix_shortest_path DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #2 aclk = ~aclk;

    // The cycle counter guards against a hung block.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void wipe_edges();
        for (int a = 0; a < NV; a++)
            for (int b = 0; b < NV; b++) begin
                has_edge[a][b] = 1'b0;
                weight_of[a][b] = '0;
            end
    endfunction

    function automatic logic [31:0] cost_sum(logic [31:0] a, logic [23:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Applies a command to the local model and queues the beats it causes.
    function automatic void predict_command(logic [1:0] cmd, logic [5:0] src, logic [5:0] dst,
                                            logic [23:0] w, logic ow);
        int          n, cur, hops;
        logic [31:0] cost_at [NV];
        logic        done [NV];
        logic        seen [NV];
        int          prev [NV];
        int          chain [NV];
        logic        found;
        logic [31:0] c;
        path_beat_t  pb;
        n = (count_reg < 2) ? 2 : ((count_reg > NV) ? NV : count_reg);
        if (cmd == CMD_CLEAR) begin
            wipe_edges();
            return;
        end
        if (cmd == CMD_ADD_EDGE) begin
            if (src != dst) begin
                weight_of[src][dst] = w;
                has_edge[src][dst] = 1'b1;
                if (!ow) begin
                    weight_of[dst][src] = w;
                    has_edge[dst][src] = 1'b1;
                end
            end
            return;
        end
        if (cmd != CMD_QUERY) return;
        pb = '{vertex: '0, cost: '0, reached: 1'b0, last: 1'b1};
        if (src >= n || dst >= n) begin
            pending_beats.insert(pending_beats.size(), pb);
            return;
        end
        for (int i = 0; i < NV; i++) begin
            cost_at[i] = '1; done[i] = 1'b0; seen[i] = 1'b0; prev[i] = 0;
        end
        cost_at[src] = '0; seen[src] = 1'b1; prev[src] = src;
        forever begin
            found = 1'b0;
            cur = 0;
            for (int i = 0; i < n; i++)
                if (seen[i] && !done[i] && (!found || cost_at[i] < cost_at[cur])) begin
                    cur = i;
                    found = 1'b1;
                end
            if (!found) break;
            done[cur] = 1'b1;
            if (cur == dst) break;
            for (int i = 0; i < n; i++) begin
                if (i == cur || !has_edge[cur][i] || done[i]) continue;
                c = cost_sum(cost_at[cur], weight_of[cur][i]);
                if (!seen[i] || c < cost_at[i]) begin
                    cost_at[i] = c; prev[i] = cur; seen[i] = 1'b1;
                end
            end
        end
        if (!done[dst]) begin
            pending_beats.insert(pending_beats.size(), pb);
            return;
        end
        hops = 0;
        cur = dst;
        chain[hops++] = cur;
        while (cur != src && hops < n) begin
            cur = prev[cur];
            chain[hops++] = cur;
        end
        for (int k = 0; k < hops; k++) begin
            pb.vertex = 6'(chain[hops - 1 - k]);
            pb.cost = cost_at[dst];
            pb.reached = 1'b1;
            pb.last = (k == hops - 1);
            pending_beats.insert(pending_beats.size(), pb);
        end
    endfunction

    // Sends one beat, with random idle cycles ahead of it, and predicts it.
    // Inputs are set at the falling edge, so back-to-back beats simply
    // overwrite the drive within that time step.
    task automatic send_command(logic [1:0] cmd, logic [5:0] src, logic [5:0] dst,
                                logic [23:0] w, logic ow);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {3'b000, ow, w, dst, src};
        do @(posedge aclk); while (!s_tready);
        predict_command(cmd, src, dst, w, ow);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Waits until all predicted beats are out and a query could have ended.
    task automatic wait_drained();
        while (pending_beats.size() != 0) @(negedge aclk);
        repeat (5000) @(negedge aclk);
    endtask

    task automatic write_count(logic [6:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        count_reg = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: random stalls, and each accepted beat against the oldest answer.
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        path_beat_t pb;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                errors++;
                $display("%0t: beat with nothing expected: vertex %0d cost %0h", $time,
                         m_tdata[5:0], m_tdata[37:6]);
            end else begin
                pb = pending_beats.pop_front();
                if (m_tdata[5:0] !== pb.vertex || m_tdata[37:6] !== pb.cost ||
                    m_tuser !== pb.reached || m_tlast !== pb.last) begin
                    errors++;
                    $display("%0t: expected v=%0d c=%0h r=%0b l=%0b, got v=%0d c=%0h r=%0b l=%0b",
                             $time, pb.vertex, pb.cost, pb.reached, pb.last,
                             m_tdata[5:0], m_tdata[37:6], m_tuser, m_tlast);
                end
            end
        end
    end

    // A chain 0-1-2-3 with maximum weights, a shorter
    // detour, a self-loop, one-way edges, a replaced weight and the endpoint cases.
    stim_row_t directed_rows[] = '{
        '{CMD_QUERY,    6'd0,  6'd63, 24'd0, 1'b0, 1'b1, '{6'd0, 32'd0, 1'b0, 1'b1}},
        '{CMD_QUERY,    6'd5,  6'd5,  24'd0, 1'b0, 1'b1, '{6'd5, 32'd0, 1'b1, 1'b1}},
        '{CMD_ADD_EDGE, 6'd0,  6'd1,  24'hFFFFFF, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{CMD_ADD_EDGE, 6'd1,  6'd2,  24'hFFFFFF, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{CMD_ADD_EDGE, 6'd2,  6'd3,  24'hFFFFFF, 1'b1, 1'b0, '{0, 0, 0, 0}},
        '{CMD_QUERY,    6'd0,  6'd3,  24'd0, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{CMD_QUERY,    6'd3,  6'd0,  24'd0, 1'b0, 1'b1, '{6'd0, 32'd0, 1'b0, 1'b1}},
        '{CMD_ADD_EDGE, 6'd7,  6'd7,  24'd5, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{CMD_QUERY,    6'd7,  6'd8,  24'd0, 1'b0, 1'b1, '{6'd0, 32'd0, 1'b0, 1'b1}},
        '{CMD_ADD_EDGE, 6'd0,  6'd63, 24'd0, 1'b1, 1'b0, '{0, 0, 0, 0}},
        '{CMD_ADD_EDGE, 6'd63, 6'd3,  24'd9, 1'b1, 1'b0, '{0, 0, 0, 0}},
        '{CMD_QUERY,    6'd0,  6'd3,  24'd0, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{CMD_ADD_EDGE, 6'd63, 6'd3,  24'hAAAAAA, 1'b1, 1'b0, '{0, 0, 0, 0}},
        '{CMD_ADD_EDGE, 6'd2,  6'd4,  24'h555555, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{CMD_QUERY,    6'd0,  6'd3,  24'd0, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{CMD_QUERY,    6'd4,  6'd0,  24'd0, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{CMD_UNUSED,   6'd1,  6'd2,  24'd3, 1'b1, 1'b0, '{0, 0, 0, 0}},
        '{CMD_CLEAR,    6'd0,  6'd0,  24'd0, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{CMD_QUERY,    6'd0,  6'd1,  24'd0, 1'b0, 1'b1, '{6'd0, 32'd0, 1'b0, 1'b1}}
    };

    // Random run: a small graph, not always cleared first, then several queries.
    task automatic random_graph(int n_max);
        int edges;
        if ($urandom_range(3) == 0)
            send_command(CMD_CLEAR, 6'($urandom), 6'($urandom), 24'($urandom), 1'($urandom));
        edges = $urandom_range(3, 9);
        for (int e = 0; e < edges; e++)
            send_command(CMD_ADD_EDGE, 6'($urandom_range(n_max - 1)),
                         6'($urandom_range(n_max - 1)),
                         ($urandom_range(7) == 0) ? 24'($urandom) : 24'($urandom_range(40)),
                         1'($urandom));
        for (int q = 0; q < 3; q++)
            send_command(CMD_QUERY, 6'($urandom_range(n_max - 1)),
                         6'($urandom_range(n_max - 1)), 24'($urandom), 1'($urandom));
        if ($urandom_range(9) == 0)
            send_command(2'($urandom), 6'($urandom), 6'($urandom), 24'($urandom),
                         1'($urandom));
    endtask

    initial begin
        stim_row_t row;
        wipe_edges();
        count_reg = 7'd64;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with no idling; typed answers are checked against the
        // search before the row is sent.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.cmd == CMD_QUERY && row.has_answer) begin
                predict_command(row.cmd, row.src, row.dst, row.weight, row.one_way);
                if (pending_beats[$].vertex !== row.answer.vertex ||
                    pending_beats[$].cost !== row.answer.cost ||
                    pending_beats[$].reached !== row.answer.reached ||
                    pending_beats[$].last !== row.answer.last) begin
                    errors++;
                    $display("%0t: table row %0d disagrees with the search", $time, i);
                end
                void'(pending_beats.pop_back());
            end
            send_command(row.cmd, row.src, row.dst, row.weight, row.one_way);
        end

        // Extremes of the count register: clamped low, smallest, over range.
        write_count(7'd0);
        send_command(CMD_ADD_EDGE, 6'd0, 6'd1, 24'd17, 1'b0);
        send_command(CMD_QUERY, 6'd1, 6'd0, 24'd0, 1'b0);
        send_command(CMD_QUERY, 6'd0, 6'd2, 24'd0, 1'b0);
        write_count(7'd127);
        send_command(CMD_QUERY, 6'd0, 6'd63, 24'd0, 1'b0);

        // Random phases, each with a count written anew and one of four idling patterns.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            write_count((ph == 5) ? 7'd64 : 7'($urandom_range(2, 12)));
            for (int g = 0; g < 2; g++) begin
                random_graph((ph == 5) ? 16 : 12);
                // The sender holds off until every answer is in.
                if (g == 0) while (pending_beats.size() != 0) @(negedge aclk);
            end
        end

        wait_drained();
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
